/* src/erm_pkg.sv */
// Package for the event rate meter: field widths, action and register codes,
// averaging weights. No dependencies.
package erm_pkg;

  localparam int RATE_W     = 40;
  localparam int TPS_W      = 21;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int ACTION_W   = 2;
  localparam int FRAMES_W   = 16;
  localparam int AVG_SUM_W  = RATE_W + 8;
  localparam int AVG_SHIFT  = 8;

  typedef logic [RATE_W-1:0]   rate_t;
  typedef logic [ACTION_W-1:0] action_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam action_t ACT_TICK  = 2'd0;
  localparam action_t ACT_ADD   = 2'd1;
  localparam action_t ACT_FLUSH = 2'd2;

  localparam cfg_idx_t CFG_COUNT_LIMIT = 2'd0;
  localparam cfg_idx_t CFG_TIME_LIMIT  = 2'd1;
  localparam cfg_idx_t CFG_TPS         = 2'd2;

  localparam logic [TPS_W-1:0] TPS_RESET = 21'd1000;
  localparam rate_t            RATE_MAX  = '1;

  localparam logic [7:0] AVG_OLD_WEIGHT = 8'd179;
  localparam logic [7:0] AVG_NEW_WEIGHT = 8'd77;

endpackage

/* src/event_rate_meter_ema_core.sv */
// Channel   | Ports                                      | Handshake
// input     | in_action, in_frame_count                  | in_valid / in_ready
// result    | out_instant_rate, out_average_rate, out_updated | out_valid / out_ready
// config    | cfg_index, cfg_data                        | cfg_we, no wait
// A transaction that recomputes the rates passes the back end through S_MUL,
// a serial divider of D = COUNTER_WIDTH+21+RATE_FRAC_BITS bits in S_DIV (skipped
// when the elapsed tick count is zero), S_AVG and S_OUT; any other transaction is
// answered straight from S_IDLE with the rates held.
// The front takes a transaction every cycle until the two-entry queue fills.
// Synchronous active-low reset; no clearing pass. A stalled result holds the
// back end; the front keeps counting until the queue is full.
// Depends on erm_pkg, erm_front, erm_queue, erm_back.
module event_rate_meter_ema_core #(
  parameter int RATE_FRAC_BITS = 8,
  parameter int COUNTER_WIDTH  = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  erm_pkg::action_t               in_action,
  input  logic [erm_pkg::FRAMES_W-1:0]   in_frame_count,
  output logic                           out_valid,
  input  logic                           out_ready,
  output erm_pkg::rate_t                 out_instant_rate,
  output erm_pkg::rate_t                 out_average_rate,
  output logic                           out_updated,
  input  logic                           cfg_we,
  input  erm_pkg::cfg_idx_t              cfg_index,
  input  logic [erm_pkg::CFG_DATA_W-1:0] cfg_data
);
  import erm_pkg::*;

  localparam int QDW = 2 * COUNTER_WIDTH + 1;

  logic [CFG_DATA_W-1:0] count_limit_r;
  logic [CFG_DATA_W-1:0] time_limit_r;
  logic [TPS_W-1:0]      tps_r;

  logic           q_push, q_pop, q_full, q_empty;
  logic [QDW-1:0] q_push_data, q_pop_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_limit_r <= '0;
      time_limit_r  <= '0;
      tps_r         <= TPS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_COUNT_LIMIT: count_limit_r <= cfg_data;
        CFG_TIME_LIMIT:  time_limit_r  <= cfg_data;
        CFG_TPS:         tps_r         <= cfg_data[TPS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  erm_front #(
    .COUNTER_WIDTH(COUNTER_WIDTH)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_action     (in_action),
    .in_frame_count(in_frame_count),
    .count_limit   (count_limit_r),
    .time_limit    (time_limit_r),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_push_data   (q_push_data)
  );

  erm_queue #(
    .WIDTH(QDW)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_data(q_push_data),
    .pop      (q_pop),
    .pop_data (q_pop_data),
    .full     (q_full),
    .empty    (q_empty)
  );

  erm_back #(
    .COUNTER_WIDTH (COUNTER_WIDTH),
    .RATE_FRAC_BITS(RATE_FRAC_BITS)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_empty         (q_empty),
    .q_data          (q_pop_data),
    .q_pop           (q_pop),
    .ticks_per_second(tps_r),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_instant_rate(out_instant_rate),
    .out_average_rate(out_average_rate),
    .out_updated     (out_updated)
  );

  a_no_result_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_limits_off_no_update: assert property (@(posedge clk) disable iff (!rst_n)
    q_push && (in_action == ACT_ADD) && (count_limit_r == '0) && (time_limit_r == '0)
    |-> !q_push_data[QDW-1])
    else $error("add transaction requested an update with both limits off");

  a_flush_idle_no_update: assert property (@(posedge clk) disable iff (!rst_n)
    q_push && (in_action == ACT_FLUSH) && (q_push_data[COUNTER_WIDTH-1:0] == '0)
    |-> !q_push_data[QDW-1])
    else $error("flush without elapsed ticks requested an update");

endmodule

/* src/erm_front.sv */
// Front end of the rate meter: accepts transactions, keeps the saturating frame
// and tick counters and decides which transactions recompute the rates.
// Depends on erm_pkg.
module erm_front #(
  parameter int COUNTER_WIDTH = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  erm_pkg::action_t                  in_action,
  input  logic [erm_pkg::FRAMES_W-1:0]      in_frame_count,
  input  logic [erm_pkg::CFG_DATA_W-1:0]    count_limit,
  input  logic [erm_pkg::CFG_DATA_W-1:0]    time_limit,
  input  logic                              q_full,
  output logic                              q_push,
  output logic [2*COUNTER_WIDTH:0]          q_push_data
);
  import erm_pkg::*;

  localparam int CW   = COUNTER_WIDTH;
  localparam int CMPW = (CW > CFG_DATA_W) ? CW : CFG_DATA_W;

  logic [CW-1:0] frame_total_r, frame_total_nxt;
  logic [CW-1:0] elapsed_r, elapsed_nxt;
  logic [CW:0]   ft_sum;
  logic [CW-1:0] ft_add;
  logic [CW-1:0] ent_frames;
  logic          hit;
  logic          upd;
  logic          fire;

  assign in_ready = !q_full;
  assign fire     = in_valid && in_ready;

  assign ft_sum = (CW+1)'(frame_total_r) + (CW+1)'(in_frame_count);
  assign ft_add = ft_sum[CW] ? {CW{1'b1}} : ft_sum[CW-1:0];
  assign hit    = ((count_limit != '0) && (CMPW'(ft_add) > CMPW'(count_limit))) ||
                  ((time_limit != '0) && (CMPW'(elapsed_r) > CMPW'(time_limit)));

  always_comb begin
    frame_total_nxt = frame_total_r;
    elapsed_nxt     = elapsed_r;
    upd             = 1'b0;
    ent_frames      = frame_total_r;
    unique case (in_action)
      ACT_TICK: begin
        if (elapsed_r != {CW{1'b1}}) begin
          elapsed_nxt = elapsed_r + CW'(1);
        end
      end
      ACT_ADD: begin
        frame_total_nxt = ft_add;
        ent_frames      = ft_add;
        if (hit) begin
          upd             = 1'b1;
          frame_total_nxt = '0;
          elapsed_nxt     = '0;
        end
      end
      ACT_FLUSH: begin
        upd             = (elapsed_r != '0);
        frame_total_nxt = '0;
        elapsed_nxt     = '0;
      end
      default: begin
      end
    endcase
  end

  assign q_push      = fire;
  assign q_push_data = {upd, ent_frames, elapsed_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_total_r <= '0;
      elapsed_r     <= '0;
    end else if (fire) begin
      frame_total_r <= frame_total_nxt;
      elapsed_r     <= elapsed_nxt;
    end
  end

endmodule

/* src/erm_queue.sv */
// Two-entry queue between front and back of the rate meter.
// Depends on nothing.
module erm_queue #(
  parameter int WIDTH = 65
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             full,
  output logic             empty
);

  logic [WIDTH-1:0] entry_r [2];
  logic             wr_ptr_r, rd_ptr_r;
  logic [1:0]       count_r;

  assign full     = (count_r == 2'd2);
  assign empty    = (count_r == 2'd0);
  assign pop_data = entry_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

/* src/erm_back.sv */
// Back end of the rate meter: bit-serial rate division, moving average and the
// result register. Depends on erm_pkg.
module erm_back #(
  parameter int COUNTER_WIDTH  = 32,
  parameter int RATE_FRAC_BITS = 8
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         q_empty,
  input  logic [2*COUNTER_WIDTH:0]     q_data,
  output logic                         q_pop,
  input  logic [erm_pkg::TPS_W-1:0]    ticks_per_second,
  output logic                         out_valid,
  input  logic                         out_ready,
  output erm_pkg::rate_t               out_instant_rate,
  output erm_pkg::rate_t               out_average_rate,
  output logic                         out_updated
);
  import erm_pkg::*;

  localparam int CW   = COUNTER_WIDTH;
  localparam int DW   = CW + TPS_W + RATE_FRAC_BITS;
  localparam int QW   = (DW > RATE_W) ? DW : RATE_W;
  localparam int CNTW = $clog2(DW);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_MUL  = 5'b00010,
    S_DIV  = 5'b00100,
    S_AVG  = 5'b01000,
    S_OUT  = 5'b10000
  } back_state_t;

  back_state_t   state_r, state_nxt;
  logic [CW-1:0] frames_r, frames_nxt;
  logic [CW-1:0] divisor_r, divisor_nxt;
  logic [DW-1:0] num_r, num_nxt;
  logic [CW-1:0] rem_r, rem_nxt;
  logic [CNTW-1:0] cnt_r, cnt_nxt;
  logic          divz_r, divz_nxt;
  rate_t         inst_r, inst_nxt;
  rate_t         avg_r, avg_nxt;
  logic          out_valid_r, out_valid_nxt;
  rate_t         out_inst_r, out_inst_nxt;
  rate_t         out_avg_r, out_avg_nxt;
  logic          out_upd_r, out_upd_nxt;

  logic          slot_free;
  logic [DW-1:0] prod;
  logic [CW:0]   rem_try;
  logic          rem_ge;
  logic [CW:0]   rem_sub;
  logic [QW-1:0] q_ext;
  rate_t         inst_sat;
  rate_t         inst_new;
  logic [AVG_SUM_W-1:0] avg_sum;
  rate_t         avg_new;

  assign slot_free = !out_valid_r || out_ready;
  assign prod      = DW'(frames_r) * DW'(ticks_per_second);
  assign rem_try   = {rem_r, num_r[DW-1]};
  assign rem_ge    = (rem_try >= {1'b0, divisor_r});
  assign rem_sub   = rem_try - {1'b0, divisor_r};
  assign q_ext     = QW'(num_r);
  assign inst_sat  = ((q_ext >> RATE_W) != '0) ? RATE_MAX : q_ext[RATE_W-1:0];
  assign inst_new  = divz_r ? RATE_MAX : inst_sat;
  assign avg_sum   = AVG_SUM_W'(avg_r) * AVG_SUM_W'(AVG_OLD_WEIGHT) +
                     AVG_SUM_W'(inst_new) * AVG_SUM_W'(AVG_NEW_WEIGHT);
  assign avg_new   = (avg_r == '0) ? inst_new : avg_sum[AVG_SUM_W-1:AVG_SHIFT];

  always_comb begin
    state_nxt     = state_r;
    frames_nxt    = frames_r;
    divisor_nxt   = divisor_r;
    num_nxt       = num_r;
    rem_nxt       = rem_r;
    cnt_nxt       = cnt_r;
    divz_nxt      = divz_r;
    inst_nxt      = inst_r;
    avg_nxt       = avg_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_inst_nxt  = out_inst_r;
    out_avg_nxt   = out_avg_r;
    out_upd_nxt   = out_upd_r;
    q_pop         = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (!q_empty && slot_free) begin
          q_pop = 1'b1;
          if (q_data[2*CW]) begin
            frames_nxt  = q_data[2*CW-1:CW];
            divisor_nxt = q_data[CW-1:0];
            state_nxt   = S_MUL;
          end else begin
            out_valid_nxt = 1'b1;
            out_inst_nxt  = inst_r;
            out_avg_nxt   = avg_r;
            out_upd_nxt   = 1'b0;
          end
        end
      end
      S_MUL: begin
        num_nxt   = prod << RATE_FRAC_BITS;
        rem_nxt   = '0;
        cnt_nxt   = CNTW'(DW - 1);
        divz_nxt  = (divisor_r == '0);
        state_nxt = (divisor_r == '0) ? S_AVG : S_DIV;
      end
      S_DIV: begin
        rem_nxt = rem_ge ? rem_sub[CW-1:0] : rem_try[CW-1:0];
        num_nxt = {num_r[DW-2:0], rem_ge};
        cnt_nxt = cnt_r - CNTW'(1);
        if (cnt_r == '0) begin
          state_nxt = S_AVG;
        end
      end
      S_AVG: begin
        inst_nxt  = inst_new;
        avg_nxt   = avg_new;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_inst_nxt  = inst_r;
          out_avg_nxt   = avg_r;
          out_upd_nxt   = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      inst_r      <= '0;
      avg_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      inst_r      <= inst_nxt;
      avg_r       <= avg_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    frames_r   <= frames_nxt;
    divisor_r  <= divisor_nxt;
    num_r      <= num_nxt;
    rem_r      <= rem_nxt;
    cnt_r      <= cnt_nxt;
    divz_r     <= divz_nxt;
    out_inst_r <= out_inst_nxt;
    out_avg_r  <= out_avg_nxt;
    out_upd_r  <= out_upd_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_instant_rate = out_inst_r;
  assign out_average_rate = out_avg_r;
  assign out_updated      = out_upd_r;

endmodule
